>>> rtl/core/cds_pkg.sv
package cds_pkg;

  localparam int MAX_NESTING = 64;
  localparam int NUM_SYMBOLS = 64;
  localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);
  localparam int SYM_W       = 6;
  localparam int MASK_W      = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [2:0] ACT_PLAIN  = 3'd0;
  localparam logic [2:0] ACT_IF     = 3'd1;
  localparam logic [2:0] ACT_IFDEF  = 3'd2;
  localparam logic [2:0] ACT_IFNDEF = 3'd3;
  localparam logic [2:0] ACT_ELIF   = 3'd4;
  localparam logic [2:0] ACT_ELSE   = 3'd5;
  localparam logic [2:0] ACT_ENDIF  = 3'd6;
  localparam logic [2:0] ACT_END    = 3'd7;

  localparam logic [2:0] ERR_OK          = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd1;
  localparam logic [2:0] ERR_NO_SYMBOL   = 3'd2;
  localparam logic [2:0] ERR_ELIF        = 3'd3;
  localparam logic [2:0] ERR_STRAY_ELSE  = 3'd4;
  localparam logic [2:0] ERR_DUP_ELSE    = 3'd5;
  localparam logic [2:0] ERR_STRAY_ENDIF = 3'd6;
  localparam logic [2:0] ERR_UNCLOSED    = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFINED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPLEMENT = 2'd2;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_KNOWN   = 2'd1,
    KIND_IGNORED = 2'd2
  } kind_t;

  typedef struct packed {
    logic             has_sym;
    logic [SYM_W-1:0] sym;
    kind_t            kind;
    logic             up_emit;
    logic             up_scan;
    logic             cond;
    logic             else_seen;
  } frame_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic mark_else;
  } stk_ctl_t;

  typedef struct packed {
    logic               valid;
    logic [SYM_W-1:0]   idx;
    logic [DEPTH_W-1:0] cnt;
    logic               hit;
  } token_t;

endpackage

>>> rtl/core/cds_cell.sv
module cds_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  cds_pkg::stk_ctl_t ctl,
  input  cds_pkg::frame_t   frame_prev,
  input  cds_pkg::frame_t   frame_next,
  output cds_pkg::frame_t   frame_q,
  input  cds_pkg::token_t   tok_in,
  output cds_pkg::token_t   tok_out
);

  cds_pkg::frame_t frame_r;
  cds_pkg::frame_t frame_nxt;
  cds_pkg::token_t tok_r;
  cds_pkg::token_t tok_nxt;
  logic            occupied;

  always_comb begin
    frame_nxt = frame_r;
    if (ctl.push) begin
      frame_nxt = frame_prev;
    end else if (ctl.pop) begin
      frame_nxt = frame_next;
    end else if (ctl.mark_else) begin
      frame_nxt.else_seen = 1'b1;
    end
  end

  // The token counts down the frames still on the stack; cells past the top
  // of the stack hold stale frames and must not match.
  assign occupied = (tok_in.cnt != '0);

  always_comb begin
    tok_nxt       = tok_in;
    tok_nxt.cnt   = occupied ? tok_in.cnt - 1'b1 : tok_in.cnt;
    tok_nxt.hit   = tok_in.hit | (occupied & frame_r.has_sym & (frame_r.sym == tok_in.idx));
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

  always_ff @(posedge clk) begin
    tok_r.idx <= tok_nxt.idx;
    tok_r.cnt <= tok_nxt.cnt;
    tok_r.hit <= tok_nxt.hit;
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
  end

  assign frame_q = frame_r;
  assign tok_out = tok_r;

endmodule

>>> rtl/core/conditional_directive_stack_top.sv
// An ifdef or ifndef line that names a symbol first sends a search token along the chain
// of stack cells, one cell a cycle, and executes once the token leaves the last cell.
// Every other line goes straight from the idle state to the execute state.
// One line is in flight at a time; the next line is taken while a result waits.
// Reset is synchronous and active low; it empties the stack and sets both flags.
module conditional_directive_stack_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cds_pkg::MASK_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      in_action,
  input  logic                            in_symbol_present,
  input  logic                            in_symbol_found,
  input  logic [cds_pkg::SYM_W-1:0]       in_symbol_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_keep_line,
  output logic                            out_emits_before,
  output logic                            out_emits_after,
  output logic                            out_scans_before,
  output logic                            out_scans_after,
  output logic [2:0]                      out_error_code
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EXEC   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [cds_pkg::MASK_W-1:0]  defined_r;
  logic [cds_pkg::MASK_W-1:0]  ignored_r;
  logic                        complement_r;
  logic [cds_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic                        emit_r, emit_nxt;
  logic                        scan_r, scan_nxt;

  logic [2:0]                  act_r;
  logic                        present_r;
  logic                        found_r;
  logic [cds_pkg::SYM_W-1:0]   idx_r;
  logic                        hit_r;

  logic                        out_valid_r;
  logic                        keep_r;
  logic                        eb_r, ea_r, sb_r, sa_r;
  logic [2:0]                  err_r;

  logic                        in_fire;
  logic                        exec_fire;
  logic                        needs_search;

  cds_pkg::stk_ctl_t           ctl;
  cds_pkg::stk_ctl_t           cell_ctl [cds_pkg::MAX_NESTING];
  cds_pkg::frame_t             frame_q  [cds_pkg::MAX_NESTING];
  cds_pkg::frame_t             frame_pv [cds_pkg::MAX_NESTING];
  cds_pkg::frame_t             frame_nx [cds_pkg::MAX_NESTING];
  cds_pkg::token_t             tok      [cds_pkg::MAX_NESTING + 1];
  cds_pkg::frame_t             new_frame;
  cds_pkg::frame_t             top_frame;

  logic                        raw;
  logic [2:0]                  err;
  logic                        is_line;
  logic                        at_max;
  logic                        known_sym;
  logic                        sym_cond;
  cds_pkg::kind_t              sym_kind;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign exec_fire = (state_r == ST_EXEC) & (~out_valid_r | out_ready);

  assign needs_search = ((in_action == cds_pkg::ACT_IFDEF) ||
                         (in_action == cds_pkg::ACT_IFNDEF)) && in_symbol_present;

  assign tok[0] = '{valid: in_fire & needs_search, idx: in_symbol_index,
                    cnt: depth_r, hit: 1'b0};

  genvar gi;
  generate
    for (gi = 0; gi < cds_pkg::MAX_NESTING; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign frame_pv[gi] = new_frame;
        assign cell_ctl[gi] = ctl;
      end else begin : g_body
        assign frame_pv[gi] = frame_q[gi-1];
        assign cell_ctl[gi] = '{push: ctl.push, pop: ctl.pop, mark_else: 1'b0};
      end
      if (gi == cds_pkg::MAX_NESTING - 1) begin : g_tail
        assign frame_nx[gi] = frame_q[gi];
      end else begin : g_link
        assign frame_nx[gi] = frame_q[gi+1];
      end
      cds_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cell_ctl[gi]),
        .frame_prev (frame_pv[gi]),
        .frame_next (frame_nx[gi]),
        .frame_q    (frame_q[gi]),
        .tok_in     (tok[gi]),
        .tok_out    (tok[gi+1])
      );
    end
  endgenerate

  assign top_frame = frame_q[0];
  assign at_max    = (depth_r == cds_pkg::DEPTH_W'(cds_pkg::MAX_NESTING));
  assign known_sym = found_r & ~hit_r &
                     ({1'b0, idx_r} < (cds_pkg::SYM_W+1)'(cds_pkg::NUM_SYMBOLS));
  assign sym_cond  = defined_r[idx_r] ^ (act_r == cds_pkg::ACT_IFNDEF);
  assign sym_kind  = !known_sym    ? cds_pkg::KIND_UNKNOWN :
                     ignored_r[idx_r] ? cds_pkg::KIND_IGNORED : cds_pkg::KIND_KNOWN;

  always_comb begin
    raw       = 1'b0;
    err       = cds_pkg::ERR_OK;
    is_line   = 1'b1;
    ctl       = '0;
    depth_nxt = depth_r;
    emit_nxt  = emit_r;
    scan_nxt  = scan_r;
    new_frame = '{has_sym: 1'b0, sym: '0, kind: cds_pkg::KIND_UNKNOWN, up_emit: emit_r,
                  up_scan: scan_r, cond: 1'b0, else_seen: 1'b0};
    unique case (act_r)
      cds_pkg::ACT_PLAIN: begin
        raw = emit_r;
      end
      cds_pkg::ACT_IF: begin
        raw = emit_r;
        if (at_max) begin
          err = cds_pkg::ERR_OVERFLOW;
        end else begin
          ctl.push  = 1'b1;
          depth_nxt = depth_r + 1'b1;
        end
      end
      cds_pkg::ACT_IFDEF, cds_pkg::ACT_IFNDEF: begin
        if (!present_r) begin
          err = cds_pkg::ERR_NO_SYMBOL;
        end else begin
          raw               = emit_r & (sym_kind != cds_pkg::KIND_KNOWN);
          new_frame.has_sym = known_sym;
          new_frame.sym     = idx_r;
          new_frame.kind    = sym_kind;
          new_frame.cond    = known_sym & sym_cond;
          if (at_max) begin
            err = cds_pkg::ERR_OVERFLOW;
          end else begin
            ctl.push  = 1'b1;
            depth_nxt = depth_r + 1'b1;
            if (sym_kind == cds_pkg::KIND_KNOWN) begin
              emit_nxt = emit_r & sym_cond;
            end else if (sym_kind == cds_pkg::KIND_IGNORED) begin
              scan_nxt = scan_r & sym_cond;
            end
          end
        end
      end
      cds_pkg::ACT_ELIF: begin
        err = cds_pkg::ERR_ELIF;
      end
      cds_pkg::ACT_ELSE: begin
        if (depth_r == '0) begin
          err = cds_pkg::ERR_STRAY_ELSE;
        end else if (top_frame.else_seen) begin
          err = cds_pkg::ERR_DUP_ELSE;
        end else begin
          raw           = top_frame.up_emit & (top_frame.kind != cds_pkg::KIND_KNOWN);
          ctl.mark_else = 1'b1;
          if (top_frame.kind == cds_pkg::KIND_KNOWN) begin
            emit_nxt = top_frame.up_emit & ~top_frame.cond;
          end else if (top_frame.kind == cds_pkg::KIND_IGNORED) begin
            scan_nxt = top_frame.up_scan & ~top_frame.cond;
          end else begin
            emit_nxt = top_frame.up_emit;
            scan_nxt = top_frame.up_scan;
          end
        end
      end
      cds_pkg::ACT_ENDIF: begin
        if (depth_r == '0) begin
          err = cds_pkg::ERR_STRAY_ENDIF;
        end else begin
          raw       = top_frame.up_emit & (top_frame.kind != cds_pkg::KIND_KNOWN);
          emit_nxt  = top_frame.up_emit;
          scan_nxt  = top_frame.up_scan;
          ctl.pop   = 1'b1;
          depth_nxt = depth_r - 1'b1;
        end
      end
      cds_pkg::ACT_END: begin
        is_line = 1'b0;
        if (depth_r != '0) begin
          err = cds_pkg::ERR_UNCLOSED;
        end
      end
    endcase
    if (!exec_fire) begin
      ctl       = '0;
      depth_nxt = depth_r;
      emit_nxt  = emit_r;
      scan_nxt  = scan_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = needs_search ? ST_SEARCH : ST_EXEC;
        end
      end
      ST_SEARCH: begin
        if (tok[cds_pkg::MAX_NESTING].valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      depth_r      <= '0;
      emit_r       <= 1'b1;
      scan_r       <= 1'b1;
      defined_r    <= '0;
      ignored_r    <= '0;
      complement_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      emit_r      <= emit_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= exec_fire | (out_valid_r & ~out_ready);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cds_pkg::CFG_DEFINED) begin
          defined_r <= cfg_data;
        end else if (cfg_index == cds_pkg::CFG_IGNORED) begin
          ignored_r <= cfg_data;
        end else if (cfg_index == cds_pkg::CFG_COMPLEMENT) begin
          complement_r <= cfg_data[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r     <= in_action;
      present_r <= in_symbol_present;
      found_r   <= in_symbol_found;
      idx_r     <= in_symbol_index;
      hit_r     <= 1'b0;
    end else if (state_r == ST_SEARCH && tok[cds_pkg::MAX_NESTING].valid) begin
      hit_r <= tok[cds_pkg::MAX_NESTING].hit;
    end
    if (exec_fire) begin
      keep_r <= ((err == cds_pkg::ERR_OK) && is_line) ? (raw ^ complement_r) : 1'b0;
      eb_r   <= emit_r;
      ea_r   <= emit_nxt;
      sb_r   <= scan_r;
      sa_r   <= scan_nxt;
      err_r  <= err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_keep_line    = keep_r;
  assign out_emits_before = eb_r;
  assign out_emits_after  = ea_r;
  assign out_scans_before = sb_r;
  assign out_scans_after  = sa_r;
  assign out_error_code   = err_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= cds_pkg::DEPTH_W'(cds_pkg::MAX_NESTING))
    else $error("stack depth beyond nesting limit");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result beat without execution");

  a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok[cds_pkg::MAX_NESTING].valid |-> (state_r == ST_SEARCH))
    else $error("search token finished outside search");

  a_error_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && err != cds_pkg::ERR_OK) |=> ($stable(depth_r) && $stable(emit_r) &&
                                               $stable(scan_r)))
    else $error("error line changed the stack state");

  a_no_push_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !at_max)
    else $error("push on a full stack");

endmodule

>>> tb/conditional_directive_stack_top_tb.sv
module conditional_directive_stack_top_tb;
  import cds_pkg::*;

  localparam int IDLE_PCT     = 21;
  localparam int CALM_FROM    = 500;
  localparam int CALM_TO      = 700;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_LINES  = 145;
  localparam int SCRIPT_ROWS  = 25;

  typedef struct packed {
    logic [2:0]       action;
    logic             present;
    logic             found;
    logic [SYM_W-1:0] index;
  } line_t;

  typedef struct packed {
    logic       keep;
    logic       emits_before;
    logic       emits_after;
    logic       scans_before;
    logic       scans_after;
    logic [2:0] err;
  } verdict_t;

  typedef struct packed {
    line_t    line;
    logic     typed;
    verdict_t want;
  } row_t;

  localparam verdict_t NONE = '0;

  // Rows with typed set carry their expected result in the row; the others are predicted by decide_line.
  localparam row_t SCRIPT [SCRIPT_ROWS] = '{
    '{'{ACT_END,    1'b0, 1'b0, 6'd0},  1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ERR_OK}},
    '{'{ACT_PLAIN,  1'b1, 1'b1, 6'd63}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, ERR_OK}},
    '{'{ACT_ELIF,   1'b1, 1'b1, 6'd63}, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ERR_ELIF}},
    '{'{ACT_ELSE,   1'b0, 1'b0, 6'd0},  1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ERR_STRAY_ELSE}},
    '{'{ACT_ENDIF,  1'b0, 1'b0, 6'd0},  1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ERR_STRAY_ENDIF}},
    '{'{ACT_IFDEF,  1'b0, 1'b1, 6'd42}, 1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ERR_NO_SYMBOL}},
    '{'{ACT_IFNDEF, 1'b0, 1'b0, 6'd21}, 1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ERR_NO_SYMBOL}},
    '{'{ACT_IFDEF,  1'b1, 1'b1, 6'd63}, 1'b0, NONE},
    '{'{ACT_PLAIN,  1'b0, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_IFNDEF, 1'b1, 1'b1, 6'd63}, 1'b0, NONE},
    '{'{ACT_ELSE,   1'b0, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_ELSE,   1'b1, 1'b1, 6'd5},  1'b0, NONE},
    '{'{ACT_ENDIF,  1'b0, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_ELSE,   1'b0, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_END,    1'b0, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_ENDIF,  1'b0, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_IFNDEF, 1'b1, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_IF,     1'b1, 1'b1, 6'd0},  1'b0, NONE},
    '{'{ACT_ENDIF,  1'b0, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_ENDIF,  1'b0, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_IFNDEF, 1'b1, 1'b1, 6'd0},  1'b0, NONE},
    '{'{ACT_IF,     1'b0, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_ENDIF,  1'b0, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_ENDIF,  1'b0, 1'b0, 6'd0},  1'b0, NONE},
    '{'{ACT_END,    1'b0, 1'b0, 6'd0},  1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ERR_OK}}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASK_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_action = ACT_PLAIN;
  logic                 in_symbol_present = 1'b0;
  logic                 in_symbol_found = 1'b0;
  logic [SYM_W-1:0]     in_symbol_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_keep_line;
  logic                 out_emits_before;
  logic                 out_emits_after;
  logic                 out_scans_before;
  logic                 out_scans_after;
  logic [2:0]           out_error_code;

  conditional_directive_stack_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_symbol_present (in_symbol_present),
    .in_symbol_found   (in_symbol_found),
    .in_symbol_index   (in_symbol_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_keep_line     (out_keep_line),
    .out_emits_before  (out_emits_before),
    .out_emits_after   (out_emits_after),
    .out_scans_before  (out_scans_before),
    .out_scans_after   (out_scans_after),
    .out_error_code    (out_error_code)
  );

  always #2 clk = ~clk;

  frame_t            frames [MAX_NESTING];
  int unsigned       stack_level = 0;
  logic              emit_on = 1'b1;
  logic              scan_on = 1'b1;
  logic [MASK_W-1:0] defined_bits = '0;
  logic [MASK_W-1:0] ignored_bits = '0;
  logic              invert_keep = 1'b0;

  verdict_t    awaited_verdicts [$];
  int unsigned lines_sent = 0;
  int unsigned verdicts_seen = 0;
  int unsigned error_lines = 0;
  int unsigned deepest = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches = 0;
  int unsigned stalled_cycles = 0;

  function automatic logic symbol_on_stack(logic [SYM_W-1:0] sym);
    for (int unsigned i = 0; i < stack_level; i++) begin
      if (frames[i].has_sym && frames[i].sym == sym) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] open_frame(kind_t kind, logic has, logic [SYM_W-1:0] sym,
                                            logic cond);
    if (stack_level >= MAX_NESTING) return ERR_OVERFLOW;
    frames[stack_level] = '{has_sym: has, sym: sym, kind: kind, up_emit: emit_on,
                            up_scan: scan_on, cond: cond, else_seen: 1'b0};
    stack_level++;
    if (kind == KIND_KNOWN) emit_on = emit_on & cond;
    else if (kind == KIND_IGNORED) scan_on = scan_on & cond;
    return ERR_OK;
  endfunction

  function automatic verdict_t decide_line(line_t l);
    verdict_t v;
    logic     raw;
    logic     is_line;
    logic     has;
    logic     cond;
    kind_t    kind;
    frame_t   f;
    v = '0;
    v.emits_before = emit_on;
    v.scans_before = scan_on;
    v.err = ERR_OK;
    raw = 1'b0;
    is_line = 1'b1;
    case (l.action)
      ACT_PLAIN: raw = emit_on;
      ACT_IF: begin
        raw = emit_on;
        v.err = open_frame(KIND_UNKNOWN, 1'b0, '0, 1'b0);
      end
      ACT_IFDEF, ACT_IFNDEF: begin
        if (!l.present) begin
          v.err = ERR_NO_SYMBOL;
        end else begin
          kind = KIND_UNKNOWN;
          has = 1'b0;
          cond = 1'b0;
          if (l.found && int'(l.index) < NUM_SYMBOLS && !symbol_on_stack(l.index)) begin
            has = 1'b1;
            cond = defined_bits[l.index] ^ (l.action == ACT_IFNDEF);
            kind = ignored_bits[l.index] ? KIND_IGNORED : KIND_KNOWN;
          end
          raw = emit_on && kind != KIND_KNOWN;
          v.err = open_frame(kind, has, l.index, cond);
        end
      end
      ACT_ELIF: v.err = ERR_ELIF;
      ACT_ELSE: begin
        if (stack_level == 0) begin
          v.err = ERR_STRAY_ELSE;
        end else begin
          f = frames[stack_level - 1];
          if (f.else_seen) begin
            v.err = ERR_DUP_ELSE;
          end else begin
            raw = f.up_emit && f.kind != KIND_KNOWN;
            frames[stack_level - 1].else_seen = 1'b1;
            if (f.kind == KIND_KNOWN) begin
              emit_on = f.up_emit & ~f.cond;
            end else if (f.kind == KIND_IGNORED) begin
              scan_on = f.up_scan & ~f.cond;
            end else begin
              emit_on = f.up_emit;
              scan_on = f.up_scan;
            end
          end
        end
      end
      ACT_ENDIF: begin
        if (stack_level == 0) begin
          v.err = ERR_STRAY_ENDIF;
        end else begin
          f = frames[stack_level - 1];
          raw = f.up_emit && f.kind != KIND_KNOWN;
          emit_on = f.up_emit;
          scan_on = f.up_scan;
          stack_level--;
        end
      end
      default: begin
        is_line = 1'b0;
        if (stack_level != 0) v.err = ERR_UNCLOSED;
      end
    endcase
    v.keep = (v.err == ERR_OK && is_line) ? raw ^ invert_keep : 1'b0;
    v.emits_after = emit_on;
    v.scans_after = scan_on;
    return v;
  endfunction

  task automatic send_line(input line_t l, input logic typed, input verdict_t given);
    verdict_t predicted;
    predicted = decide_line(l);
    awaited_verdicts.push_back(typed ? given : predicted);
    if (predicted.err != ERR_OK) error_lines++;
    if (stack_level > deepest) deepest = stack_level;
    while (!(lines_sent >= CALM_FROM && lines_sent < CALM_TO) &&
           $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= l.action;
    in_symbol_present <= l.present;
    in_symbol_found   <= l.found;
    in_symbol_index   <= l.index;
    do @(posedge clk); while (!in_ready);
    lines_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEFINED: defined_bits = data;
      CFG_IGNORED: ignored_bits = data;
      CFG_COMPLEMENT: invert_keep = data[0];
      default: ;
    endcase
  endtask

  // Registers change only once the block has delivered every pending result.
  task automatic apply_setting(input logic [MASK_W-1:0] defined, input logic [MASK_W-1:0] ignored,
                               input logic complement);
    in_valid <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
    write_reg(CFG_DEFINED, defined);
    write_reg(CFG_IGNORED, ignored);
    write_reg(CFG_COMPLEMENT, MASK_W'(complement));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic line_t pick_push();
    line_t l;
    case ($urandom_range(4))
      0: l.action = ACT_IF;
      1, 2: l.action = ACT_IFDEF;
      default: l.action = ACT_IFNDEF;
    endcase
    l.present = ($urandom_range(15) != 0);
    l.found   = ($urandom_range(5) != 0);
    l.index   = ($urandom_range(2) == 0) ? SYM_W'($urandom) : SYM_W'($urandom_range(7));
    return l;
  endfunction

  // Mostly balanced nesting with random symbols; a few percent of lines are arbitrary.
  function automatic line_t pick_line();
    line_t l;
    int    sel;
    l = pick_push();
    sel = $urandom_range(99);
    if (sel < 3) l.action = 3'($urandom_range(7));
    else if (sel < 33) l.action = ACT_PLAIN;
    else if (sel < 63) begin
      if (stack_level >= 10) l.action = ACT_ENDIF;
    end else if (stack_level != 0) begin
      l.action = (sel < 78) ? ACT_ELSE : ACT_ENDIF;
    end
    return l;
  endfunction

  task automatic fill_and_overflow();
    line_t l;
    while (stack_level < MAX_NESTING) begin
      l = pick_push();
      l.present = 1'b1;
      send_line(l, 1'b0, NONE);
    end
    l = pick_push();
    l.action = ACT_IF;
    send_line(l, 1'b0, NONE);
    l.action = ACT_IFDEF;
    l.present = 1'b1;
    l.found = 1'b1;
    send_line(l, 1'b0, NONE);
    while (stack_level != 0) begin
      l = pick_push();
      case ($urandom_range(3))
        0: l.action = ACT_ELSE;
        1: l.action = ACT_PLAIN;
        default: l.action = ACT_ENDIF;
      endcase
      send_line(l, 1'b0, NONE);
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (awaited_verdicts.size() == 0) begin
      $error("result beat with nothing expected");
      mismatches++;
      return;
    end
    want = awaited_verdicts.pop_front();
    compare_field("keep_line", want.keep, out_keep_line);
    compare_field("emits_before", want.emits_before, out_emits_before);
    compare_field("emits_after", want.emits_after, out_emits_after);
    compare_field("scans_before", want.scans_before, out_scans_before);
    compare_field("scans_after", want.scans_after, out_scans_after);
    compare_field("error_code", want.err, out_error_code);
  endtask

  // The receiver holds off once for a long stretch so that the block backs up.
  initial begin : result_side
    int unsigned hold_left;
    logic        held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        check_verdict();
        verdicts_seen++;
      end
      if (!held && verdicts_seen == HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= (verdicts_seen >= CALM_FROM && verdicts_seen < CALM_TO) ||
                     $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == STALL_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin : stimulus
    for (int i = 0; i < MAX_NESTING; i++) frames[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      send_line(SCRIPT[r].line, SCRIPT[r].typed, SCRIPT[r].want);
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_setting('0, '1, 1'b1);
        1: apply_setting('1, '0, 1'b0);
        2: apply_setting('1, '1, 1'b1);
        3: apply_setting('0, '0, 1'b0);
        default: apply_setting({$urandom, $urandom}, {$urandom, $urandom},
                               1'($urandom_range(1)));
      endcase
      if (ph == 3) fill_and_overflow();
      repeat (PHASE_LINES) send_line(pick_line(), 1'b0, NONE);
    end
    in_valid <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d lines (%0d with error codes) under %0d register settings;",
             lines_sent, error_lines, settings_used);
    $display("nesting reached depth %0d, including the overflow case.", deepest);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/cds_pkg.sv
rtl/core/cds_cell.sv
rtl/core/conditional_directive_stack_top.sv
tb/conditional_directive_stack_top_tb.sv
